>>> rtl/lol_pkg.sv
// Shared constants, types and helper functions for the landmark observation
// likelihood block. No dependencies; every other rtl file imports this package.
`default_nettype none

package lol_pkg;

  // Field widths
  localparam int POS_W      = 24;
  localparam int ANG_W      = 19;
  localparam int RNG_W      = 24;
  localparam int VAR_W      = 32;
  localparam int STD_W      = 24;
  localparam int COST_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [VAR_W-1:0] ANGLE_VAR_RST   = 32'd671089;
  localparam logic [VAR_W-1:0] HEADING_VAR_RST = 32'd5110;
  localparam logic [STD_W-1:0] RANGE_BASE_RST  = 24'd32768;
  localparam logic [STD_W-1:0] GATE_RST        = 24'd262144;

  // Register index map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_VAR   = 2'd0,
    REG_HEADING_VAR = 2'd1,
    REG_RANGE_BASE  = 2'd2,
    REG_GATE        = 2'd3
  } cfg_reg_e;

  // Polar conversion
  localparam int DIFF_W       = POS_W + 1;
  localparam int CORDIC_STEPS = 20;
  localparam int GUARD_BITS   = 8;
  localparam int XW           = 36;
  localparam int ZW           = 24;
  localparam int ANGLE_W      = ZW - 4;
  localparam int ANGLE_SHIFT  = 4;
  localparam logic signed [ZW-1:0] ANGLE_ROUND = 24'sd8;
  localparam logic signed [ZW-1:0] Q20_PI      = 24'sd3294199;
  localparam logic signed [ZW-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
    24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
    24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
    24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
  };

  // Gain correction of the magnitude
  localparam int GAIN_W    = 16;
  localparam logic [GAIN_W-1:0] CORDIC_INV_GAIN = 16'd39797;
  localparam int PROD_W    = XW - 1 + GAIN_W;
  localparam int MAG_SHIFT = 24;
  localparam logic [PROD_W-1:0] MAG_ROUND = PROD_W'(64'd1 << (MAG_SHIFT - 1));
  localparam int MAG_W     = 26;

  // Innovations and their squares
  localparam int INN_W  = 22;
  localparam int WRAP_W = 23;
  localparam int ABS_W  = ANG_W - 1;
  localparam int RI_W   = MAG_W + 1;
  localparam int SD_W   = STD_W + 1;
  localparam int ASQ_W  = 2 * ABS_W;
  localparam int RSQ_W  = 2 * MAG_W;
  localparam int SDSQ_W = 2 * SD_W;
  localparam int ANG_FRAC_SHIFT = 7;
  localparam int RNG_FRAC_SHIFT = 15;
  localparam logic signed [WRAP_W-1:0] W_PI     = 23'sd205887;
  localparam logic signed [WRAP_W-1:0] W_TWO_PI = 23'sd411775;

  // Cost terms
  localparam logic [COST_W-1:0] MIN_TERM = 32'd294912;
  localparam logic [COST_W-1:0] MIN_POS  = 32'd589824;
  localparam int SUM_W = COST_W + 2;

  // Pipeline depths, accept edge to result strobe
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int DIV_LAT    = COST_W + 1;
  localparam int LATENCY    = 1 + CORDIC_LAT + 4 + DIV_LAT + 1;

  // Wrap an angle into [-pi, pi] and return its magnitude
  function automatic logic [ABS_W-1:0] wrap_abs(input logic signed [INN_W-1:0] v);
    logic signed [WRAP_W-1:0] r;
    r = WRAP_W'(v) + W_PI;
    if (r < 0) r = r + W_TWO_PI;
    if (r < 0) r = r + W_TWO_PI;
    if (r >= W_TWO_PI) r = r - W_TWO_PI;
    if (r >= W_TWO_PI) r = r - W_TWO_PI;
    r = r - W_PI;
    if (r < 0) r = -r;
    return ABS_W'(r);
  endfunction

endpackage

`default_nettype wire

>>> rtl/landmark_observation_likelihood.sv
// Top level of the landmark observation likelihood pipeline: config registers,
// polar conversion, innovations, three dividers and the cost sum.
// Depends on lol_pkg, lol_cordic and lol_div.
//
//  channel   handshake            payload
//  input     start / busy         has_association_i .. obs_heading_i
//  result    done_o strobe        cost_o, min_cost_o, unassociated_o
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One word enters per cycle; busy stays low. Each word passes the input stage,
// the 21-stage CORDIC chain, the gain, innovation, wrap and square stages,
// the 33-stage divider and the output register. Reset clears the valid
// bits and loads the register defaults.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none

module landmark_observation_likelihood (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   has_association_i,
  input  wire logic                                   position_known_i,
  input  wire logic                                   orientation_known_i,
  input  wire logic signed [lol_pkg::POS_W-1:0]       particle_x_i,
  input  wire logic signed [lol_pkg::POS_W-1:0]       particle_y_i,
  input  wire logic signed [lol_pkg::ANG_W-1:0]       particle_heading_i,
  input  wire logic signed [lol_pkg::POS_W-1:0]       landmark_x_i,
  input  wire logic signed [lol_pkg::POS_W-1:0]       landmark_y_i,
  input  wire logic signed [lol_pkg::ANG_W-1:0]       landmark_heading_i,
  input  wire logic        [lol_pkg::RNG_W-1:0]       obs_range_i,
  input  wire logic signed [lol_pkg::ANG_W-1:0]       obs_bearing_i,
  input  wire logic signed [lol_pkg::ANG_W-1:0]       obs_heading_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [lol_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [lol_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                                        done_o,
  output logic             [lol_pkg::COST_W-1:0]      cost_o,
  output logic             [lol_pkg::COST_W-1:0]      min_cost_o,
  output logic                                        unassociated_o
);
  import lol_pkg::*;

  typedef struct packed {
    logic                    assoc;
    logic                    pos_ok;
    logic                    ori_ok;
    logic [RNG_W-1:0]        rng;
    logic signed [ANG_W-1:0] ob;
    logic signed [ANG_W-1:0] ph;
    logic signed [ANG_W-1:0] oh;
    logic signed [ANG_W-1:0] lh;
  } side_t;

  typedef struct packed {
    logic assoc;
    logic pos_ok;
    logic ori_ok;
    logic pos_use;
  } flags_t;

  logic [VAR_W-1:0] angle_variance_q, heading_variance_q;
  logic [STD_W-1:0] range_std_base_q, gate_distance_q;

  logic accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_variance_q   <= ANGLE_VAR_RST;
      heading_variance_q <= HEADING_VAR_RST;
      range_std_base_q   <= RANGE_BASE_RST;
      gate_distance_q    <= GATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ANGLE_VAR:   angle_variance_q   <= cfg_wdata_i[VAR_W-1:0];
        REG_HEADING_VAR: heading_variance_q <= cfg_wdata_i[VAR_W-1:0];
        REG_RANGE_BASE:  range_std_base_q   <= cfg_wdata_i[STD_W-1:0];
        REG_GATE:        gate_distance_q    <= cfg_wdata_i[STD_W-1:0];
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input stage
  logic                    v0_q;
  side_t                   sb0_q;
  logic signed [POS_W-1:0] px_q, py_q, lx_q, ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    sb0_q <= '{assoc: has_association_i, pos_ok: position_known_i,
               ori_ok: orientation_known_i, rng: obs_range_i, ob: obs_bearing_i,
               ph: particle_heading_i, oh: obs_heading_i, lh: landmark_heading_i};
    px_q  <= particle_x_i;
    py_q  <= particle_y_i;
    lx_q  <= landmark_x_i;
    ly_q  <= landmark_y_i;
  end

  // Polar conversion of the landmark offset
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [ZW-1:0]     cor_ang;
  logic        [XW-2:0]     cor_mag;

  assign dx = DIFF_W'(lx_q) - DIFF_W'(px_q);
  assign dy = DIFF_W'(ly_q) - DIFF_W'(py_q);

  lol_cordic u_cordic (
    .clk_i (clk_i),
    .dx_i  (dx),
    .dy_i  (dy),
    .ang_o (cor_ang),
    .mag_o (cor_mag)
  );

  // Carry the side fields alongside the CORDIC
  logic  vc_q  [0:CORDIC_LAT-1];
  side_t sbc_q [0:CORDIC_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CORDIC_LAT; i++) vc_q[i] <= 1'b0;
    end else begin
      vc_q[0] <= v0_q;
      for (int i = 1; i < CORDIC_LAT; i++) vc_q[i] <= vc_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sbc_q[0] <= sb0_q;
    for (int i = 1; i < CORDIC_LAT; i++) sbc_q[i] <= sbc_q[i-1];
  end

  // Gain correction and angle rounding
  logic                      vm_q;
  side_t                     sbm_q;
  logic [PROD_W-1:0]         prod_q;
  logic signed [ANGLE_W-1:0] angm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else         vm_q <= vc_q[CORDIC_LAT-1];
  end

  always_ff @(posedge clk_i) begin
    sbm_q  <= sbc_q[CORDIC_LAT-1];
    prod_q <= PROD_W'(cor_mag) * PROD_W'(CORDIC_INV_GAIN);
    angm_q <= ANGLE_W'((cor_ang + ANGLE_ROUND) >>> ANGLE_SHIFT);
  end

  // Raw innovations, range std dev and gate
  logic [MAG_W-1:0]         mag;
  logic                     v1_q;
  flags_t                   fl1_q;
  logic signed [RI_W-1:0]   ri1_q;
  logic signed [INN_W-1:0]  bv1_q, hv1_q;
  logic [SD_W-1:0]          sd1_q;

  assign mag = MAG_W'((prod_q + MAG_ROUND) >> MAG_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    fl1_q <= '{assoc: sbm_q.assoc, pos_ok: sbm_q.pos_ok, ori_ok: sbm_q.ori_ok,
               pos_use: sbm_q.pos_ok && (sbm_q.rng < gate_distance_q)};
    ri1_q <= RI_W'(sbm_q.rng) - RI_W'(mag);
    bv1_q <= INN_W'(sbm_q.ob) - INN_W'(angm_q) + INN_W'(sbm_q.ph);
    hv1_q <= INN_W'(sbm_q.oh) - INN_W'(sbm_q.lh) + INN_W'(sbm_q.ph);
    sd1_q <= SD_W'(range_std_base_q) + SD_W'(sbm_q.rng >> 2);
  end

  // Wrap angles and take magnitudes
  logic             v2_q;
  flags_t           fl2_q;
  logic [ABS_W-1:0] ub2_q, uh2_q;
  logic [MAG_W-1:0] ur2_q;
  logic [SD_W-1:0]  sd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    fl2_q <= fl1_q;
    ub2_q <= wrap_abs(bv1_q);
    uh2_q <= wrap_abs(hv1_q);
    ur2_q <= MAG_W'((ri1_q < 0) ? -ri1_q : ri1_q);
    sd2_q <= sd1_q;
  end

  // Squares
  logic              v3_q;
  flags_t            fl3_q;
  logic [ASQ_W-1:0]  bsq3_q, hsq3_q;
  logic [RSQ_W-1:0]  rsq3_q;
  logic [SDSQ_W-1:0] sdsq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    fl3_q   <= fl2_q;
    bsq3_q  <= ASQ_W'(ub2_q) * ASQ_W'(ub2_q);
    hsq3_q  <= ASQ_W'(uh2_q) * ASQ_W'(uh2_q);
    rsq3_q  <= RSQ_W'(ur2_q) * RSQ_W'(ur2_q);
    sdsq3_q <= SDSQ_W'(sd2_q) * SDSQ_W'(sd2_q);
  end

  // Term dividers
  logic [COST_W-1:0] term_b, term_r, term_h;

  lol_div #(.NW(ASQ_W + ANG_FRAC_SHIFT), .DW(VAR_W)) u_div_bearing (
    .clk_i (clk_i),
    .n_i   ({bsq3_q, {ANG_FRAC_SHIFT{1'b0}}}),
    .d_i   (angle_variance_q),
    .q_o   (term_b)
  );

  lol_div #(.NW(RSQ_W + RNG_FRAC_SHIFT), .DW(SDSQ_W)) u_div_range (
    .clk_i (clk_i),
    .n_i   ({rsq3_q, {RNG_FRAC_SHIFT{1'b0}}}),
    .d_i   (sdsq3_q),
    .q_o   (term_r)
  );

  lol_div #(.NW(ASQ_W + ANG_FRAC_SHIFT), .DW(VAR_W)) u_div_heading (
    .clk_i (clk_i),
    .n_i   ({hsq3_q, {ANG_FRAC_SHIFT{1'b0}}}),
    .d_i   (heading_variance_q),
    .q_o   (term_h)
  );

  // Carry flags alongside the dividers
  logic   vd_q [0:DIV_LAT-1];
  flags_t fd_q [0:DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else begin
      vd_q[0] <= v3_q;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fd_q[0] <= fl3_q;
    for (int i = 1; i < DIV_LAT; i++) fd_q[i] <= fd_q[i-1];
  end

  // Sum the terms and saturate
  flags_t            fl_out;
  logic [SUM_W-1:0]  sum;
  logic [COST_W-1:0] cost_d, min_d;

  always_comb begin
    fl_out = fd_q[DIV_LAT-1];
    sum    = '0;
    min_d  = '0;
    if (fl_out.pos_use) sum = SUM_W'(term_b) + SUM_W'(term_r);
    if (fl_out.ori_ok)  sum = sum + SUM_W'(term_h);
    if (fl_out.pos_ok)  min_d = MIN_POS;
    if (fl_out.ori_ok)  min_d = min_d + MIN_TERM;
    cost_d = (sum[SUM_W-1:COST_W] != '0) ? '1 : sum[COST_W-1:0];
    if (!fl_out.assoc) begin
      cost_d = '1;
      min_d  = '1;
    end
  end

  // Output word
  logic              done_q, unassoc_q;
  logic [COST_W-1:0] cost_q, min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vd_q[DIV_LAT-1];
  end

  always_ff @(posedge clk_i) begin
    cost_q    <= cost_d;
    min_q     <= min_d;
    unassoc_q <= !fl_out.assoc;
  end

  assign done_o         = done_q;
  assign cost_o         = cost_q;
  assign min_cost_o     = min_q;
  assign unassociated_o = unassoc_q;

endmodule

`default_nettype wire

>>> rtl/lol_cordic.sv
// Pipelined vectoring CORDIC: offset vector to angle (Q20) and scaled magnitude.
// One rotation step per stage, CORDIC_LAT register stages. Depends on lol_pkg.
`default_nettype none

module lol_cordic (
  input  wire logic                               clk_i,
  input  wire logic signed [lol_pkg::DIFF_W-1:0]  dx_i,
  input  wire logic signed [lol_pkg::DIFF_W-1:0]  dy_i,
  output logic signed [lol_pkg::ZW-1:0]           ang_o,
  output logic        [lol_pkg::XW-2:0]           mag_o
);
  import lol_pkg::*;

  logic signed [XW-1:0] x_in, y_in, x_pre, y_pre;
  logic signed [ZW-1:0] z_pre;
  logic                 zero_in;

  logic signed [XW-1:0] x_q [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_q [0:CORDIC_STEPS-1];
  logic signed [ZW-1:0] z_q [0:CORDIC_STEPS];
  logic                 zf_q [0:CORDIC_STEPS];

  logic signed [XW-1:0] x_d [1:CORDIC_STEPS];
  logic signed [XW-1:0] y_d [1:CORDIC_STEPS-1];
  logic signed [ZW-1:0] z_d [1:CORDIC_STEPS];

  // Scale up and fold the left half plane onto the right
  always_comb begin
    x_in    = XW'(dx_i) <<< GUARD_BITS;
    y_in    = XW'(dy_i) <<< GUARD_BITS;
    zero_in = (dx_i == '0) && (dy_i == '0);
    x_pre   = x_in;
    y_pre   = y_in;
    z_pre   = '0;
    if (x_in < 0) begin
      x_pre = -x_in;
      y_pre = -y_in;
      z_pre = (y_in >= 0) ? Q20_PI : -Q20_PI;
    end
  end

  // Rotation steps, one per stage
  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!y_q[i][XW-1]) begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        z_d[i+1] = z_q[i] + ATAN_Q20[i];
      end else begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        z_d[i+1] = z_q[i] - ATAN_Q20[i];
      end
    end
    for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
      if (!y_q[i][XW-1]) begin
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
      end else begin
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
      end
    end
  end

  // Advance the stage registers
  always_ff @(posedge clk_i) begin
    x_q[0]  <= x_pre;
    y_q[0]  <= y_pre;
    z_q[0]  <= z_pre;
    zf_q[0] <= zero_in;
    for (int i = 1; i <= CORDIC_STEPS; i++) begin
      x_q[i]  <= x_d[i];
      z_q[i]  <= z_d[i];
      zf_q[i] <= zf_q[i-1];
    end
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      y_q[i] <= y_d[i];
    end
  end

  // Coincident points give angle zero; magnitude is already zero
  assign ang_o = zf_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];
  assign mag_o = x_q[CORDIC_STEPS][XW-2:0];

endmodule

`default_nettype wire

>>> rtl/lol_div.sv
// Pipelined restoring divider: floor(n / d) saturated to COST_W bits, one
// quotient bit per stage after a saturation check stage. Depends on lol_pkg.
`default_nettype none

module lol_div #(
  parameter int NW = lol_pkg::ASQ_W + lol_pkg::ANG_FRAC_SHIFT,
  parameter int DW = lol_pkg::VAR_W
) (
  input  wire logic                         clk_i,
  input  wire logic [NW-1:0]                n_i,
  input  wire logic [DW-1:0]                d_i,
  output logic      [lol_pkg::COST_W-1:0]   q_o
);
  import lol_pkg::*;

  localparam int HW = NW - COST_W;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0]     r_q   [0:COST_W-1];
  logic [COST_W-1:0] lo_q  [0:COST_W-1];
  logic [DW-1:0]     d_q   [0:COST_W-1];
  logic [COST_W-1:0] q_q   [0:COST_W];
  logic              sat_q [0:COST_W];

  logic [DW:0]       rs    [0:COST_W-1];
  logic              ge    [0:COST_W-1];
  logic [DW-1:0]     r_d   [1:COST_W-1];

  // Trial subtract for each quotient bit
  always_comb begin
    for (int k = 0; k < COST_W; k++) begin
      rs[k] = {r_q[k], lo_q[k][COST_W-1]};
      ge[k] = rs[k] >= {1'b0, d_q[k]};
    end
    for (int k = 0; k < COST_W - 1; k++) begin
      r_d[k+1] = ge[k] ? DW'(rs[k] - {1'b0, d_q[k]}) : DW'(rs[k]);
    end
  end

  // Saturation check, then advance the bit stages
  always_ff @(posedge clk_i) begin
    sat_q[0] <= CW'(n_i[NW-1:COST_W]) >= CW'(d_i);
    r_q[0]   <= DW'(n_i[NW-1:COST_W]);
    lo_q[0]  <= n_i[COST_W-1:0];
    d_q[0]   <= d_i;
    q_q[0]   <= '0;
    for (int k = 1; k <= COST_W; k++) begin
      q_q[k]   <= {q_q[k-1][COST_W-2:0], ge[k-1]};
      sat_q[k] <= sat_q[k-1];
    end
    for (int k = 1; k < COST_W; k++) begin
      r_q[k]  <= r_d[k];
      lo_q[k] <= lo_q[k-1] << 1;
      d_q[k]  <= d_q[k-1];
    end
  end

  assign q_o = sat_q[COST_W] ? '1 : q_q[COST_W];

endmodule

`default_nettype wire

>>> rtl/lol_checker.sv
// Port-level checks for the landmark observation likelihood block, bound to
// the top level. Depends on lol_pkg.
`default_nettype none

module lol_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          has_association_i,
  input wire logic                          done_o,
  input wire logic [lol_pkg::COST_W-1:0]    cost_o,
  input wire logic [lol_pkg::COST_W-1:0]    min_cost_o,
  input wire logic                          unassociated_o
);
  import lol_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] settle_q;

  // Count cycles since reset, hold at the pipeline depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else if (settle_q != CNT_W'(LATENCY)) begin
      settle_q <= settle_q + 1'b1;
    end
  end

  a_unassoc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && unassociated_o |-> (cost_o == '1) && (min_cost_o == '1))
    else $error("unassociated word without saturated costs");

  a_min_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !unassociated_o |->
      (min_cost_o == '0) || (min_cost_o == MIN_TERM) || (min_cost_o == MIN_POS) ||
      (min_cost_o == MIN_POS + MIN_TERM))
    else $error("minimum cost outside its fixed set");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle_q == CNT_W'(LATENCY) |-> done_o == $past(start && !busy, LATENCY))
    else $error("result strobe does not match accepted word");

  a_assoc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q == CNT_W'(LATENCY)) && done_o |->
      unassociated_o == !$past(has_association_i, LATENCY))
    else $error("unassociated flag does not follow its word");

endmodule

bind landmark_observation_likelihood lol_checker u_lol_checker (.*);

`default_nettype wire

>>> test/landmark_observation_likelihood_tb.sv
// Testbench for landmark_observation_likelihood: directed and random pairs,
// with the cost predicted and checked in order. Depends on lol_pkg and the RTL.
`default_nettype none

module landmark_observation_likelihood_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lol_pkg::*;

  localparam longint unsigned SAT = 64'hFFFF_FFFF;
  localparam longint HALF_TURN = 205887;
  localparam longint FULL_TURN = 411775;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic assoc, pos_ok, ori_ok;
    logic signed [POS_W-1:0] px, py, lx, ly;
    logic signed [ANG_W-1:0] ph, lh, ob, oh;
    logic [RNG_W-1:0] rng;
  } pair_t;

  typedef struct {
    logic [COST_W-1:0] cost, min_cost;
    logic unassoc;
  } score_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start = 1'b0, busy;
  logic has_association_i = 1'b0, position_known_i = 1'b0, orientation_known_i = 1'b0;
  logic signed [POS_W-1:0] particle_x_i = '0, particle_y_i = '0;
  logic signed [POS_W-1:0] landmark_x_i = '0, landmark_y_i = '0;
  logic signed [ANG_W-1:0] particle_heading_i = '0, landmark_heading_i = '0;
  logic signed [ANG_W-1:0] obs_bearing_i = '0, obs_heading_i = '0;
  logic [RNG_W-1:0] obs_range_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic done_o, unassociated_o;
  logic [COST_W-1:0] cost_o, min_cost_o;

  // Predictor copy of the registers
  longint unsigned bearing_var, heading_var, std_base, gate;
  score_t pending_scores[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  landmark_observation_likelihood dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // CORDIC vectoring: bearing in Q16, range in Q8.16
  function automatic void to_polar(input longint dx, input longint dy,
                                   output longint ang, output longint unsigned mag);
    longint atan_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                             8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    longint x, y, z, xs, ys;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (dx == 0 && dy == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? 3294199 : -3294199;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    ang = (z + 8) >>> 4;
    mag = (longint'(x) * 39797 + (64'd1 << 23)) >> 24;
  endfunction

  function automatic longint unsigned wrapped_abs(input longint v);
    longint r;
    r = (v + HALF_TURN) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    r -= HALF_TURN;
    return (r < 0) ? -r : r;
  endfunction

  // Fixed point quotient n*2^f/d, saturating
  function automatic longint unsigned scaled_quot(input longint unsigned n,
                                                  input longint unsigned d, input int f);
    longint unsigned q, r;
    if (d == 0) return SAT;
    q = n / d;
    r = n % d;
    if (q > (SAT >> f)) return SAT;
    for (int i = 0; i < f; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        q |= 1;
        r -= d;
      end
    end
    return (q > SAT) ? SAT : q;
  endfunction

  function automatic longint unsigned add_sat(input longint unsigned a, b);
    return (a + b > SAT) ? SAT : a + b;
  endfunction

  function automatic score_t predict_score(input pair_t p);
    score_t s;
    longint ang, ri;
    longint unsigned mag, ub, ur, uh, sd, cost, minc;
    cost = 0;
    minc = 0;
    if (!p.assoc) begin
      s.cost = '1; s.min_cost = '1; s.unassoc = 1'b1;
      return s;
    end
    if (p.pos_ok) begin
      minc += 2 * 294912;
      if (p.rng < gate) begin
        to_polar(longint'(p.lx) - longint'(p.px), longint'(p.ly) - longint'(p.py), ang, mag);
        ub = wrapped_abs(longint'(p.ob) - ang + longint'(p.ph));
        cost = add_sat(cost, scaled_quot(ub * ub, bearing_var, 7));
        ri = longint'({40'd0, p.rng}) - longint'(mag);
        ur = (ri < 0) ? -ri : ri;
        sd = std_base + (p.rng >> 2);
        cost = add_sat(cost, scaled_quot(ur * ur, sd * sd, 15));
      end
    end
    if (p.ori_ok) begin
      uh = wrapped_abs(longint'(p.oh) - (longint'(p.lh) - longint'(p.ph)));
      minc += 294912;
      cost = add_sat(cost, scaled_quot(uh * uh, heading_var, 7));
    end
    s.cost = cost[31:0];
    s.min_cost = minc[31:0];
    s.unassoc = 1'b0;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got, want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Track registers, queue predictions and check each result word
  always @(posedge clk_i or negedge rst_ni) begin
    score_t want;
    pair_t p;
    if (!rst_ni) begin
      bearing_var <= 671089;
      heading_var <= 5110;
      std_base <= 32768;
      gate <= 262144;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ANGLE_VAR:   bearing_var <= cfg_wdata_i;
          REG_HEADING_VAR: heading_var <= cfg_wdata_i;
          REG_RANGE_BASE:  std_base <= cfg_wdata_i[23:0];
          REG_GATE:        gate <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        p.assoc = has_association_i; p.pos_ok = position_known_i;
        p.ori_ok = orientation_known_i;
        p.px = particle_x_i; p.py = particle_y_i; p.ph = particle_heading_i;
        p.lx = landmark_x_i; p.ly = landmark_y_i; p.lh = landmark_heading_i;
        p.rng = obs_range_i; p.ob = obs_bearing_i; p.oh = obs_heading_i;
        pending_scores = {pending_scores, predict_score(p)};
      end
      if (done_o) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("unexpected word", cost_o, 0);
        end else begin
          want = pending_scores.pop_front();
          if (cost_o !== want.cost) report_mismatch("cost", cost_o, want.cost);
          if (min_cost_o !== want.min_cost) report_mismatch("min_cost", min_cost_o, want.min_cost);
          if (unassociated_o !== want.unassoc)
            report_mismatch("unassociated", unassociated_o, want.unassoc);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("landmark_observation_likelihood_tb: errors");
      $finish;
    end
  end

  // Drive one word and hold it until accepted; idle now and then
  task automatic send_pair(input pair_t p);
    has_association_i <= p.assoc; position_known_i <= p.pos_ok;
    orientation_known_i <= p.ori_ok;
    particle_x_i <= p.px; particle_y_i <= p.py; particle_heading_i <= p.ph;
    landmark_x_i <= p.lx; landmark_y_i <= p.ly; landmark_heading_i <= p.lh;
    obs_range_i <= p.rng; obs_bearing_i <= p.ob; obs_heading_i <= p.oh;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    while (!calm && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Wait for every expected word, then let the pipeline settle
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle;
    if ($urandom_range(9) == 0) return ANG_W'($urandom);
    return ANG_W'(longint'($urandom_range(411774)) - HALF_TURN);
  endfunction

  function automatic pair_t rand_pair;
    pair_t p;
    p.assoc = ($urandom_range(15) != 0);
    p.pos_ok = $urandom_range(3) != 0;
    p.ori_ok = 1'($urandom_range(1));
    p.px = POS_W'($urandom);
    p.py = POS_W'($urandom);
    if ($urandom_range(1)) begin
      p.lx = p.px + POS_W'($urandom_range(2**20) - 2**19);
      p.ly = p.py + POS_W'($urandom_range(2**20) - 2**19);
    end else begin
      p.lx = POS_W'($urandom);
      p.ly = POS_W'($urandom);
    end
    p.ph = rand_angle(); p.lh = rand_angle();
    p.ob = rand_angle(); p.oh = rand_angle();
    if (gate != 0 && $urandom_range(3) != 0) p.rng = RNG_W'($urandom_range(32'(gate - 1)));
    else p.rng = RNG_W'($urandom);
    return p;
  endfunction

  function automatic pair_t base_pair;
    pair_t p;
    p.assoc = 1'b1; p.pos_ok = 1'b1; p.ori_ok = 1'b1;
    p.px = 24'sd65536; p.py = -24'sd65536; p.ph = 19'sd51471;
    p.lx = 24'sd196608; p.ly = 24'sd131072; p.lh = -19'sd100000;
    p.rng = 24'd180000; p.ob = 19'sd20000; p.oh = 19'sd30000;
    return p;
  endfunction

  // Missing association, each flag alone, gate edge, coincident positions, offsets along the negative x axis
  task automatic test_special_cases;
    pair_t p;
    p = base_pair(); p.assoc = 1'b0; send_pair(p);
    p = base_pair(); send_pair(p);
    p = base_pair(); p.ori_ok = 1'b0; send_pair(p);
    p = base_pair(); p.pos_ok = 1'b0; send_pair(p);
    p = base_pair(); p.pos_ok = 1'b0; p.ori_ok = 1'b0; send_pair(p);
    p = base_pair(); p.rng = 24'd262144; send_pair(p);
    p = base_pair(); p.rng = 24'd262143; send_pair(p);
    p = base_pair(); p.lx = p.px; p.ly = p.py; send_pair(p);
    p = base_pair(); p.lx = 24'sd0; p.px = 24'sd65536; p.ly = p.py; send_pair(p);
    p = base_pair(); p.lx = -24'sd65536; p.px = 24'sd0; p.ly = 24'sd5; p.py = 24'sd5;
    send_pair(p);
    drain();
  endtask

  // Field extremes and angles outside the half turn
  task automatic test_extremes;
    pair_t p;
    p = base_pair(); p.px = -24'sd8388608; p.py = -24'sd8388608;
    p.lx = 24'sd8388607; p.ly = 24'sd8388607; p.rng = 24'd0; send_pair(p);
    p = base_pair(); p.px = 24'sd8388607; p.lx = -24'sd8388608; p.py = '0; p.ly = '0;
    send_pair(p);
    p = base_pair(); p.ph = -19'sd262144; p.lh = 19'sd262143; p.ob = 19'sd262143;
    p.oh = -19'sd262144; send_pair(p);
    p = base_pair(); p.ph = 19'sd205887; p.lh = -19'sd205887; p.ob = -19'sd205887;
    p.oh = 19'sd205887; send_pair(p);
    p = base_pair(); p.rng = 24'd0; p.lx = 24'sd8388607; p.px = -24'sd8388608; send_pair(p);
    drain();
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      send_pair(rand_pair());
    end
    calm = 0;
    drain();
  endtask

  // Smallest variances and zero base deviation, widest gate
  task automatic test_config_low;
    pair_t p;
    write_reg(REG_ANGLE_VAR, 32'd1);
    write_reg(REG_HEADING_VAR, 32'd1);
    write_reg(REG_RANGE_BASE, 32'd0);
    write_reg(REG_GATE, 32'hFF_FFFF);
    p = base_pair(); p.rng = 24'd3; send_pair(p);
    p = base_pair(); p.rng = 24'd0; p.lx = p.px; p.ly = p.py; send_pair(p);
    p = base_pair(); p.rng = 24'hFF_FFFE; send_pair(p);
    drain();
    run_random(250);
  endtask

  // Largest variances and base deviation, closed gate, then a gate at half range
  task automatic test_config_high;
    write_reg(REG_ANGLE_VAR, 32'hFFFF_FFFF);
    write_reg(REG_HEADING_VAR, 32'hFFFF_FFFF);
    write_reg(REG_RANGE_BASE, 32'hFF_FFFF);
    write_reg(REG_GATE, 32'd0);
    run_random(100);
    write_reg(REG_GATE, 32'h80_0000);
    run_random(150);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_extremes();
    run_random(350);
    test_config_low();
    test_config_high();
    if (errors == 0) begin
      $display("landmark_observation_likelihood_tb: clean");
    end else begin
      $display("landmark_observation_likelihood_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
